// ===== hw/rtl/hmap_pkg.sv =====
// Shared constants, codes and payload types for the hit map accumulator.
// Depends on nothing; the channel interfaces and the core import it.
`default_nettype none
package hmap_pkg;

   localparam int MAP_COLS   = 256;
   localparam int MAP_ROWS   = 256;
   localparam int COUNT_BITS = 16;

   localparam int X_BITS     = $clog2(MAP_COLS);
   localparam int Y_BITS     = $clog2(MAP_ROWS);
   localparam int ADDR_BITS  = X_BITS + Y_BITS;
   localparam int CELL_DEPTH = 1 << ADDR_BITS;
   localparam int CELL_W     = COUNT_BITS + 32 + 3;

   localparam int LIST_DEPTH     = 65536;
   localparam int LIST_ADDR_BITS = 16;
   localparam int LEN_BITS       = 17;
   localparam int FRAME_BITS     = 9;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [31:0] COORD_MASK = 32'h7fffffff;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIST,
      ST_CELL,
      ST_REPLY,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] hit_x;
      logic [31:0] hit_y;
      logic [31:0] hit_color;
      logic [2:0]  source_index;
      logic [15:0] list_index;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        first_hit;
      logic [7:0]  cell_x;
      logic [7:0]  cell_y;
      logic [15:0] cell_count;
      logic [31:0] cell_color;
      logic [2:0]  cell_source;
      logic [15:0] peak_count;
      logic [16:0] list_length;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_BITS-1:0] index;
      logic [FRAME_BITS-1:0]   data;
   } csr_type;

endpackage
`default_nettype wire

// ===== hw/rtl/hmap_channels.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on hmap_pkg for the payload types.
`default_nettype none
interface hmap_req_if;
   import hmap_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hmap_rsp_if;
   import hmap_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hmap_csr_if;
   import hmap_pkg::*;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hmap_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module hmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/hit_map_accumulator_core.sv =====
// Hit map accumulator: cell store and first-hit list in RAM, request sequencer.
// Depends on hmap_pkg, the channel interfaces and hmap_ram.
//
// Usage:
// Requests arrive on req_chan: clear the map, add a hit, or read an entry of
// the first-hit list. Every request gives exactly one response on rsp_chan.
// Frame width and height are written on csr_chan (index 0 and 1); the user must
// write them only while no request is in flight; the block does not enforce it.
// csr_chan is always ready. On the way to a response in the output register, an
// add inside the frame issues the cell read at the accepting edge, then
// modifies, writes back and loads the response from ST_CELL; a list read passes
// ST_LIST (list read), then ST_CELL (cell read); a rejected or unused request
// loads from ST_REPLY. Each load waits for a free output register. The next
// request is taken in the cycle after the response is loaded. A clear
// sweeps the cell RAM one entry per cycle over CELL_DEPTH entries (65536).
// After reset the same sweep runs without a response; no request is accepted
// during it. When the receiver stalls, one response waits in the output
// register while the next request is still accepted and worked; that request
// then holds, an add before its write-back, until the output register is free.
`default_nettype none
module hit_map_accumulator_core (
   input  wire logic clock,
   input  wire logic reset,
   hmap_req_if.sink   req_chan,
   hmap_rsp_if.source rsp_chan,
   hmap_csr_if.sink   csr_chan
);
   import hmap_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0]   LIST_FULL = LEN_BITS'(LIST_DEPTH);
   localparam logic [ADDR_BITS-1:0]  SWEEP_END = ADDR_BITS'(CELL_DEPTH - 1);

   state_type state_ff, state_in;

   logic [FRAME_BITS-1:0] frame_w_ff, frame_h_ff;
   logic [LEN_BITS-1:0]   length_ff, length_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic [ADDR_BITS-1:0]  sweep_ff, sweep_in;
   logic                  reply_ff, reply_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [1:0]           op_ff;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [31:0]          color_ff;
   logic [2:0]           src_ff;

   logic req_fire, slot_free, rsp_load;
   logic in_frame, read_ok;
   logic [31:0] lim_w, lim_h;

   logic                      cell_wr_en, cell_rd_en;
   logic [ADDR_BITS-1:0]      cell_wr_addr, cell_rd_addr;
   logic [CELL_W-1:0]         cell_wr_data, cell_rd_data;
   logic                      list_wr_en, list_rd_en;
   logic [LIST_ADDR_BITS-1:0] list_wr_addr, list_rd_addr;
   logic [ADDR_BITS-1:0]      list_wr_data, list_rd_data;

   logic [COUNT_BITS-1:0] cnt_old, cnt_new;
   logic [31:0]           color_old, color_new;
   logic [2:0]            src_old;
   logic                  first;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign lim_w = (32'(frame_w_ff) > 32'(MAP_COLS)) ? 32'(MAP_COLS) : 32'(frame_w_ff);
   assign lim_h = (32'(frame_h_ff) > 32'(MAP_ROWS)) ? 32'(MAP_ROWS) : 32'(frame_h_ff);
   assign in_frame = ((req_chan.payload.hit_x & COORD_MASK) < lim_w)
                  && ((req_chan.payload.hit_y & COORD_MASK) < lim_h);
   assign read_ok  = ({1'b0, req_chan.payload.list_index} < length_ff);

   assign cnt_old   = cell_rd_data[CELL_W-1 -: COUNT_BITS];
   assign color_old = cell_rd_data[34:3];
   assign src_old   = cell_rd_data[2:0];
   assign first     = (cnt_old == '0);
   assign cnt_new   = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         color_new[ch*8 +: 8] = 8'(({1'b0, color_old[ch*8 +: 8]}
                                  + {1'b0, color_ff[ch*8 +: 8]}) >> 1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.payload.cmd)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_ADD:   state_in = in_frame ? ST_CELL : ST_REPLY;
                  CMD_READ:  state_in = read_ok ? ST_LIST : ST_REPLY;
                  default:   state_in = ST_REPLY;
               endcase
            end
         end
         ST_LIST: state_in = ST_CELL;
         ST_CELL, ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (sweep_ff == SWEEP_END) begin
               state_in = reply_ff ? ST_REPLY : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cell_rd_en   = 1'b0;
      cell_rd_addr = {req_chan.payload.hit_y[Y_BITS-1:0], req_chan.payload.hit_x[X_BITS-1:0]};
      cell_wr_en   = 1'b0;
      cell_wr_addr = addr_ff;
      cell_wr_data = {cnt_new, color_new, src_ff};
      list_rd_en   = 1'b0;
      list_rd_addr = req_chan.payload.list_index;
      list_wr_en   = 1'b0;
      list_wr_addr = length_ff[LIST_ADDR_BITS-1:0];
      list_wr_data = addr_ff;
      addr_in      = addr_ff;
      length_in    = length_ff;
      peak_in      = peak_ff;
      sweep_in     = sweep_ff;
      reply_in     = reply_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_in = cell_rd_addr;
               case (req_chan.payload.cmd)
                  CMD_CLEAR: begin
                     length_in = '0;
                     peak_in   = '0;
                     sweep_in  = '0;
                     reply_in  = 1'b1;
                  end
                  CMD_ADD:  cell_rd_en = in_frame;
                  CMD_READ: list_rd_en = read_ok;
                  default: ;
               endcase
            end
         end
         ST_LIST: begin
            cell_rd_en   = 1'b1;
            cell_rd_addr = list_rd_data;
            addr_in      = list_rd_data;
         end
         ST_CELL: begin
            rsp_data_in.accepted = 1'b1;
            rsp_data_in.cell_x   = 8'(addr_ff[X_BITS-1:0]);
            rsp_data_in.cell_y   = 8'(addr_ff[ADDR_BITS-1:X_BITS]);
            if (op_ff == CMD_ADD) begin
               if (cnt_new > peak_ff) begin
                  peak_in = cnt_new;
               end
               if (first && length_ff < LIST_FULL) begin
                  length_in  = length_ff + 1'b1;
                  list_wr_en = slot_free;
               end
               cell_wr_en = slot_free;
               rsp_data_in.first_hit   = first;
               rsp_data_in.cell_count  = 16'(cnt_new);
               rsp_data_in.cell_color  = color_new;
               rsp_data_in.cell_source = src_ff;
            end else begin
               rsp_data_in.cell_count  = 16'(cnt_old);
               rsp_data_in.cell_color  = color_old;
               rsp_data_in.cell_source = src_old;
            end
            rsp_data_in.peak_count  = 16'(peak_in);
            rsp_data_in.list_length = length_in;
            rsp_load = slot_free;
            if (!slot_free) begin
               length_in = length_ff;
               peak_in   = peak_ff;
            end
         end
         ST_REPLY: begin
            rsp_data_in.peak_count  = 16'(peak_ff);
            rsp_data_in.list_length = length_ff;
            rsp_load = slot_free;
         end
         ST_CLEAR: begin
            cell_wr_en   = 1'b1;
            cell_wr_addr = sweep_ff;
            cell_wr_data = '0;
            sweep_in     = sweep_ff + 1'b1;
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         frame_w_ff   <= FRAME_BITS'(256);
         frame_h_ff   <= FRAME_BITS'(256);
         length_ff    <= '0;
         peak_ff      <= '0;
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         peak_ff      <= peak_in;
         sweep_ff     <= sweep_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.payload.index == REG_FRAME_WIDTH) begin
               frame_w_ff <= csr_chan.payload.data;
            end else if (csr_chan.payload.index == REG_FRAME_HEIGHT) begin
               frame_h_ff <= csr_chan.payload.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (req_fire) begin
         op_ff    <= req_chan.payload.cmd;
         color_ff <= req_chan.payload.hit_color;
         src_ff   <= req_chan.payload.source_index;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   hmap_ram #(.WIDTH(CELL_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   hmap_ram #(.WIDTH(ADDR_BITS), .DEPTH(LIST_DEPTH)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   a_write_not_idle: assert property (@(posedge clock) disable iff (reset)
      cell_wr_en |-> state_ff != ST_IDLE)
      else $error("cell write while idle");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LIST_FULL)
      else $error("list length above depth");

   a_peak_listed: assert property (@(posedge clock) disable iff (reset)
      peak_ff != '0 |-> length_ff != '0)
      else $error("peak count without any listed cell");

   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.payload.cmd == CMD_CLEAR) |=>
         (state_ff == ST_CLEAR && length_ff == '0 && peak_ff == '0))
      else $error("clear did not start a sweep");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == ST_CELL || state_ff == ST_REPLY) && slot_free)
      else $error("response loaded over a pending response");
endmodule
`default_nettype wire
